@@ rtl/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

  // page numbers and counts carry one bit more than a 16-bit page number
  localparam int PAGE_W        = 17;
  localparam int WORD_W        = 8;
  localparam int MAX_PAGES_DEF = 65536;
  localparam int PAGE_CAP      = 65536;

  // configuration register indexes
  localparam logic [1:0] CFG_TOTAL_PAGES   = 2'd0;
  localparam logic [1:0] CFG_BOOT_PAGES    = 2'd1;
  localparam logic [1:0] CFG_RESERVED_PAGE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_INIT  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_BOOT,
    ST_ALLOC,
    ST_CHECK,
    ST_DONE
  } state_t;

  // verdict of the word scan unit on the word under the search pointer
  typedef struct packed {
    logic        found;    // free page below the limit in this word
    logic        advance;  // word holds nothing free, next word still below the limit
    logic [15:0] page;     // lowest free page of the word
    logic [2:0]  bit_idx;  // its bit in the word
  } scan_res_t;

endpackage
`default_nettype wire

@@ rtl/bpa_ram.sv @@
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/bpa_scan_unit.sv @@
`default_nettype none
module bpa_scan_unit
  import bpa_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [PAGE_W-1:0] word_base,
  input  wire logic [15:0]       reserved_page,
  input  wire logic [PAGE_W-1:0] limit,
  output scan_res_t              res
);

  logic [WORD_W-1:0] free_mask;
  logic              any_free;
  logic [2:0]        low_bit;
  logic [PAGE_W-1:0] page_full;
  logic [PAGE_W-1:0] word_end;

  always_comb begin
    free_mask = ~word;
    // the reserved page never counts as free
    if (word_base[PAGE_W-1:3] == {1'b0, reserved_page[15:3]}) begin
      free_mask[reserved_page[2:0]] = 1'b0;
    end
  end

  // lowest set bit, highest index first so the lowest wins
  always_comb begin
    low_bit = 3'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        low_bit = 3'(i);
      end
    end
  end

  assign any_free  = |free_mask;
  assign page_full = word_base | {{(PAGE_W-3){1'b0}}, low_bit};
  assign word_end  = word_base + PAGE_W'(WORD_W);

  always_comb begin
    res.found   = any_free && (page_full < limit);
    res.advance = !any_free && (word_end < limit);
    res.page    = page_full[15:0];
    res.bit_idx = low_bit;
  end

endmodule
`default_nettype wire

@@ rtl/bitmap_page_allocator_core.sv @@
`default_nettype none
// bitmap page allocator: one used bit per page in a byte-wide map memory, a used count
// and a sticky out-of-memory flag
//
// channels
//   s_axis : one request per transaction, tuser = kind (allocate, query, init, no-op),
//            tdata = page number for a query
//   m_axis : exactly one result per request, in request order
//   cfg    : register writes (total_pages, boot_pages, reserved_page), always ready,
//            only to be used while no request is in flight
//
// a no-op goes straight to its result, a query reads its map word first, and an
//   allocate reads and checks the word under the search pointer, stepping it a word at
//   a time until a free page or the limit. the pointer only moves forward (pages are
//   never freed) and restarts at word 0 on init or a reserved_page write, so it normally
//   rests on the word of the next free page. init clears the whole map one word a cycle
//   (MAP_WORDS words, 8192 by default), then takes boot_pages pages like an allocate;
//   the first failure ends it. one request is worked on at a time: s_axis_tready comes
//   back the cycle after a result is loaded, even while it still waits.
//
// reset runs the same clearing pass over the map memory; s_axis_tready stays low
// until it is done. a stalled m_axis holds its result and the block waits with it.
module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] page_number
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [15:0] result_page, [16] page_used,
                                           // [17] status, [34:18] used_count,
                                           // [35] error_seen, [39:36] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  // map words: enough for the pages the limit can ever allow
  localparam int RAW_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int MAP_WORDS = (RAW_WORDS > PAGE_CAP / WORD_W) ? PAGE_CAP / WORD_W : RAW_WORDS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIMIT_CAP = (MAX_PAGES < PAGE_CAP) ? MAX_PAGES : PAGE_CAP;

  // configuration registers
  logic [PAGE_W-1:0] total_pages;
  logic [PAGE_W-1:0] boot_pages;
  logic [15:0]       reserved_page;

  // allocator state
  state_t            state, state_next;
  kind_t             op;
  logic [ADDR_W-1:0] hint;        // every word below it is used or holds only the reserved page
  logic [ADDR_W-1:0] clr_addr;
  logic [PAGE_W-1:0] used_pages;
  logic              oom_flag;
  logic [PAGE_W-1:0] boot_cnt;
  logic [15:0]       q_page;

  // result under construction
  logic [15:0]       res_page;
  logic              res_used;
  logic              res_status;

  // map memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [PAGE_W-1:0] limit;
  logic [PAGE_W-1:0] hint_base;
  scan_res_t         scan;
  logic              s_accept;
  logic              out_free;
  logic              q_in_map;
  logic              q_used;
  logic              count_full;
  logic              clr_last;

  assign limit      = (total_pages > PAGE_W'(LIMIT_CAP)) ? PAGE_W'(LIMIT_CAP) : total_pages;
  assign hint_base  = {{(PAGE_W-3-ADDR_W){1'b0}}, hint, 3'b000};
  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign count_full = used_pages >= limit;
  assign clr_last   = clr_addr == ADDR_W'(MAP_WORDS - 1);
  assign q_in_map   = int'(q_page[15:3]) < MAP_WORDS;
  assign q_used     = (q_page == reserved_page) || (q_in_map && ram_rdata[q_page[2:0]]);

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .ADDR_W(ADDR_W)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  bpa_scan_unit u_scan (
    .word         (ram_rdata),
    .word_base    (hint_base),
    .reserved_page(reserved_page),
    .limit        (limit),
    .res          (scan)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = (op == KIND_INIT) ? ST_BOOT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          unique case (kind_t'(s_axis_tuser))
            KIND_ALLOC: state_next = ST_ALLOC;
            KIND_QUERY: state_next = ST_QUERY;
            KIND_INIT:  state_next = ST_CLEAR;
            KIND_NOP:   state_next = ST_DONE;
          endcase
        end
      end
      ST_QUERY: state_next = ST_DONE;
      ST_BOOT:  state_next = (boot_cnt == boot_pages) ? ST_DONE : ST_ALLOC;
      ST_ALLOC: state_next = count_full ? ST_DONE : ST_CHECK;
      ST_CHECK: begin
        if (scan.found) begin
          state_next = (op == KIND_INIT) ? ST_BOOT : ST_DONE;
        end else if (scan.advance) begin
          state_next = ST_ALLOC;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // map memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = hint;
    ram_wdata = ram_rdata;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_addr = s_axis_tdata[3 +: ADDR_W];
      end
      ST_CHECK: begin
        ram_we    = scan.found;
        ram_wdata = ram_rdata | (WORD_W'(1) << scan.bit_idx);
      end
      default: begin
        ram_addr = hint;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      op         <= KIND_NOP;
      hint       <= '0;
      clr_addr   <= '0;
      used_pages <= '0;
      oom_flag   <= 1'b0;
      boot_cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          // a fresh map, or a new reserved page that may free a word already passed
          if ((s_accept && kind_t'(s_axis_tuser) == KIND_INIT) ||
              (cfg_valid && cfg_ready && cfg_index == CFG_RESERVED_PAGE)) begin
            hint <= '0;
          end
          if (s_accept) begin
            op         <= kind_t'(s_axis_tuser);
            q_page     <= s_axis_tdata;
            res_page   <= '0;
            res_used   <= 1'b0;
            res_status <= 1'b0;
            if (kind_t'(s_axis_tuser) == KIND_INIT) begin
              clr_addr   <= '0;
              used_pages <= '0;
              boot_cnt   <= '0;
            end
          end
        end
        ST_QUERY: begin
          res_used <= q_used;
        end
        ST_ALLOC: begin
          if (count_full) begin
            res_status <= 1'b1;
            oom_flag   <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (scan.found) begin
            used_pages <= used_pages + PAGE_W'(1);
            if (op == KIND_INIT) begin
              boot_cnt <= boot_cnt + PAGE_W'(1);
            end else begin
              res_page <= scan.page;
            end
          end else if (scan.advance) begin
            hint <= hint + ADDR_W'(1);
          end else begin
            res_status <= 1'b1;
            oom_flag   <= 1'b1;
          end
        end
        default: begin
          op <= op;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages   <= PAGE_W'(PAGE_CAP);
      boot_pages    <= '0;
      reserved_page <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_PAGES:   total_pages   <= cfg_data;
        CFG_BOOT_PAGES:    boot_pages    <= cfg_data;
        CFG_RESERVED_PAGE: reserved_page <= cfg_data[15:0];
        default:           total_pages   <= total_pages;
      endcase
    end
  end

  // output register, loaded as a request finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {4'b0000, oom_flag, used_pages, res_status, res_used, res_page};
    end
  end

  // search pointer stays inside the map
  a_hint_in_map: assert property (@(posedge clk) disable iff (rst)
    int'(hint) < MAP_WORDS)
    else $error("search pointer left the map");

  // a page taken by the search was free in the word just read
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && scan.found) |-> !ram_rdata[scan.bit_idx])
    else $error("allocated page already marked used");

  // outside idle, the used count only changes on a taken page, growing by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (used_pages != $past(used_pages) && $past(state) != ST_IDLE) |->
      (used_pages == $past(used_pages) + PAGE_W'(1) && $past(state) == ST_CHECK))
    else $error("used count moved without an allocation");

endmodule
`default_nettype wire
